// File: src/press_length_counter_blinker_unit_defines.svh
// assertion macros for the press length counter blinker unit
`ifndef PRESS_LENGTH_COUNTER_BLINKER_UNIT_DEFINES_SVH
`define PRESS_LENGTH_COUNTER_BLINKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define PLCB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next
`define PLCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLCB_ASSERT(label, prop, msg)
`define PLCB_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: src/plcb_pkg.sv
// shared types and constants of the press length counter blinker unit
`timescale 1ns / 1ps

package plcb_pkg;

  localparam int unsigned PLCB_LED_COUNT = 4;
  localparam int unsigned PLCB_LED_W     = 4;
  localparam int unsigned PLCB_TICK_W    = 16;
  localparam int unsigned PLCB_ADDR_W    = 2;

  localparam logic [PLCB_TICK_W-1:0] PLCB_LONG_RESET = 16'd1000;
  localparam logic [PLCB_TICK_W-1:0] PLCB_ON_RESET   = 16'd800;
  localparam logic [PLCB_TICK_W-1:0] PLCB_OFF_RESET  = 16'd200;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } plcb_event_e;

  typedef enum logic [PLCB_ADDR_W-1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_ON_TICKS   = 2'd1,
    REG_OFF_TICKS  = 2'd2
  } plcb_reg_e;

  typedef struct packed {
    logic [PLCB_TICK_W-1:0] long_press_ticks;
    logic [PLCB_TICK_W-1:0] on_ticks;
    logic [PLCB_TICK_W-1:0] off_ticks;
  } plcb_cfg_t;

  typedef struct packed {
    plcb_event_e           press_event;
    logic [PLCB_LED_W-1:0] count_value;
    logic [PLCB_LED_W-1:0] led_drive;
  } plcb_result_t;

endpackage

// File: src/plcb_core.sv
// press timing, counter and blink phase state with the per-tick result logic
`timescale 1ns / 1ps

module plcb_core import plcb_pkg::*; #(
  parameter int unsigned LED_COUNT = PLCB_LED_COUNT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         beat_i,
  input  logic         level_i,
  input  plcb_cfg_t    cfg_i,
  output plcb_result_t result_o
);

  localparam logic [PLCB_TICK_W-1:0] TickMax = {PLCB_TICK_W{1'b1}};

  logic                   held_flag_q, held_flag_d;
  logic [PLCB_TICK_W-1:0] held_ticks_q, held_ticks_d;
  logic [LED_COUNT-1:0]   count_q, count_d;
  logic                   blink_q, blink_d;
  logic                   lit_q, lit_d;
  logic [PLCB_TICK_W-1:0] phase_q, phase_d;

  logic                   pressed;
  logic [PLCB_TICK_W-1:0] held_inc;
  logic [PLCB_TICK_W-1:0] phase_inc;
  logic [PLCB_TICK_W-1:0] limit;
  plcb_event_e            event_w;
  logic [PLCB_LED_W-1:0]  led_w;
  logic [PLCB_LED_W-1:0]  cnt_w;

  assign pressed   = ~level_i;
  assign held_inc  = (held_ticks_q == TickMax) ? TickMax : held_ticks_q + 16'd1;
  assign phase_inc = (phase_q == TickMax) ? TickMax : phase_q + 16'd1;
  assign limit     = lit_q ? cfg_i.on_ticks : cfg_i.off_ticks;

  always_comb begin
    held_flag_d  = held_flag_q;
    held_ticks_d = held_ticks_q;
    event_w      = EV_NONE;
    if (pressed) begin
      if (held_flag_q) begin
        held_ticks_d = held_inc;
      end else begin
        held_flag_d  = 1'b1;
        held_ticks_d = '0;
      end
    end else if (held_flag_q) begin
      held_flag_d  = 1'b0;
      held_ticks_d = '0;
      event_w      = (held_inc >= cfg_i.long_press_ticks) ? EV_LONG : EV_SHORT;
    end
  end

  always_comb begin
    count_d = count_q;
    blink_d = blink_q;
    lit_d   = lit_q;
    phase_d = phase_q;
    if (event_w != EV_NONE) begin
      // any press event returns to the start of the lit phase; blinking resumes only for a nonzero count
      count_d = (event_w == EV_LONG) ? '0 : count_q + LED_COUNT'(1);
      lit_d   = 1'b1;
      phase_d = '0;
      blink_d = (count_d != '0);
    end else if (blink_q) begin
      if (phase_inc >= limit) begin
        lit_d   = ~lit_q;
        phase_d = '0;
      end else begin
        phase_d = phase_inc;
      end
    end
  end

  // fit the counter onto the fixed four-bit result fields
  for (genvar i = 0; i < PLCB_LED_W; i++) begin : g_led
    if (i < LED_COUNT) begin : g_used
      assign cnt_w[i] = count_d[i];
      assign led_w[i] = count_d[i] & lit_d;
    end else begin : g_unused
      assign cnt_w[i] = 1'b0;
      assign led_w[i] = 1'b0;
    end
  end

  assign result_o.press_event = event_w;
  assign result_o.count_value = cnt_w;
  assign result_o.led_drive   = led_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_flag_q  <= 1'b0;
      held_ticks_q <= '0;
      count_q      <= '0;
      blink_q      <= 1'b0;
      lit_q        <= 1'b1;
      phase_q      <= '0;
    end else if (beat_i) begin
      held_flag_q  <= held_flag_d;
      held_ticks_q <= held_ticks_d;
      count_q      <= count_d;
      blink_q      <= blink_d;
      lit_q        <= lit_d;
      phase_q      <= phase_d;
    end
  end

endmodule

// File: src/plcb_out_buf.sv
// two-entry result buffer: output register plus skid entry
`timescale 1ns / 1ps

module plcb_out_buf import plcb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  plcb_result_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output plcb_result_t out_data_o
);

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  plcb_result_t out_data_q, out_data_d;
  plcb_result_t skid_data_q, skid_data_d;
  logic         take;

  assign in_ready_o = ~skid_valid_q;
  assign take       = in_valid_i & ~skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = take;
        out_data_d  = in_data_i;
      end
    end else if (take) begin
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: src/press_length_counter_blinker_unit.sv
// top level of the press length counter blinker unit
`timescale 1ns / 1ps
`include "press_length_counter_blinker_unit_defines.svh"

// one input beat per millisecond tick carries the sampled button level
// (0 pressed); every beat gives exactly one result beat with the led drive,
// the counter value and the release event of that tick. a beat is taken in
// every cycle until both entries of the two-entry output buffer hold
// results not yet taken (s_axis_tready low); each beat's result is offered
// in the next cycle when the output register is free, otherwise it waits
// in the skid entry behind it. hold time saturates at 65535 ticks; a
// release at or above long_press_ticks clears the counter, a shorter one
// counts up with wrap. configuration writes complete in the cycle they are
// offered and should only be made while no result is pending.

module press_length_counter_blinker_unit import plcb_pkg::*; #(
  parameter int unsigned LED_COUNT = PLCB_LED_COUNT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [PLCB_ADDR_W-1:0] cfg_addr_i,
  input  logic [PLCB_TICK_W-1:0] cfg_data_i,
  // tick input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [0] button_level, [7:1] zero
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [3:0] led_drive, [7:4] count_value, [9:8] press_event, [15:10] zero
  output logic [15:0]            m_axis_tdata
);

  plcb_cfg_t    cfg_q;
  plcb_result_t core_res;
  plcb_result_t out_res;
  logic         beat;

  // register writes, unknown indexes ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks <= PLCB_LONG_RESET;
      cfg_q.on_ticks         <= PLCB_ON_RESET;
      cfg_q.off_ticks        <= PLCB_OFF_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data_i;
        REG_ON_TICKS:   cfg_q.on_ticks         <= cfg_data_i;
        REG_OFF_TICKS:  cfg_q.off_ticks        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state only moves on an accepted tick beat
  assign beat = s_axis_tvalid & s_axis_tready;

  plcb_core #(
    .LED_COUNT(LED_COUNT)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .level_i (s_axis_tdata[0]),
    .cfg_i   (cfg_q),
    .result_o(core_res)
  );

  plcb_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (core_res),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.press_event, out_res.count_value, out_res.led_drive};

  // lit leds are always a subset of the counter bits
  `PLCB_ASSERT(a_led_in_count,
    m_axis_tvalid |-> ((m_axis_tdata[3:0] & ~m_axis_tdata[7:4]) == 4'd0),
    "led drive outside counter value")
  // a long press always leaves the counter at zero
  `PLCB_ASSERT(a_long_clears,
    (m_axis_tvalid && (m_axis_tdata[9:8] == EV_LONG)) |-> (m_axis_tdata[7:4] == 4'd0),
    "long press with nonzero count")
  // buffer only fills up while a result is on offer
  `PLCB_ASSERT(a_full_has_out, !s_axis_tready |-> m_axis_tvalid,
    "input stalled with no result pending")
  // a result is on offer in the cycle after every accepted tick
  `PLCB_ASSERT_NEXT(a_beat_result, s_axis_tvalid && s_axis_tready, m_axis_tvalid,
    "accepted tick lost")

endmodule

// File: sim/tb_top.sv
// self-checking testbench of the press length counter blinker unit
`timescale 1ns / 1ps

module tb_top;
  import plcb_pkg::*;

  // index past the last register, writes to it must be dropped
  localparam logic [PLCB_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct {
    bit                     is_cfg;
    logic                   level;
    logic [PLCB_ADDR_W-1:0] addr;
    logic [PLCB_TICK_W-1:0] data;
  } script_item_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [PLCB_ADDR_W-1:0] cfg_addr_i = '0;
  logic [PLCB_TICK_W-1:0] cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;  // [0] button_level, [7:1] zero
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [3:0] led_drive, [7:4] count_value, [9:8] press_event, [15:10] zero
  logic [15:0]            m_axis_tdata;

  // pending ticks and register writes, filled once at time zero
  script_item_t button_script[$];
  // tick results still owed by the block, oldest first
  plcb_result_t expected_display[$];
  int unsigned  script_items;
  int unsigned  fail_cnt;

  // mirror of the block state
  plcb_cfg_t              pred_cfg;
  logic [PLCB_LED_W-1:0]  pred_count;
  logic                   pred_held;
  logic [PLCB_TICK_W-1:0] pred_held_ticks;
  logic                   pred_blink;
  logic                   pred_lit;
  logic [PLCB_TICK_W-1:0] pred_phase_ticks;

  press_length_counter_blinker_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [PLCB_TICK_W-1:0] sat_inc(input logic [PLCB_TICK_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // advance the mirrored state by one tick and return the expected result of that tick
  function automatic plcb_result_t next_tick_display(input logic level);
    plcb_result_t           res;
    plcb_event_e            ev;
    logic [PLCB_TICK_W-1:0] dur;
    logic [PLCB_TICK_W-1:0] lim;
    ev = EV_NONE;
    if (!level) begin
      // press while held just keeps timing
      if (pred_held) begin
        pred_held_ticks = sat_inc(pred_held_ticks);
      end else begin
        pred_held = 1'b1;
        pred_held_ticks = '0;
      end
    end else if (pred_held) begin
      dur = sat_inc(pred_held_ticks);
      pred_held = 1'b0;
      pred_held_ticks = '0;
      ev = (dur >= pred_cfg.long_press_ticks) ? EV_LONG : EV_SHORT;
    end
    if (ev != EV_NONE) begin
      // short press wraps from all ones to zero by the 4-bit width
      pred_count = (ev == EV_LONG) ? '0 : pred_count + 1'b1;
      pred_lit = 1'b1;
      pred_phase_ticks = '0;
      pred_blink = (pred_count != '0);
    end else if (pred_blink) begin
      lim = pred_lit ? pred_cfg.on_ticks : pred_cfg.off_ticks;
      pred_phase_ticks = sat_inc(pred_phase_ticks);
      if (pred_phase_ticks >= lim) begin
        pred_lit = ~pred_lit;
        pred_phase_ticks = '0;
      end
    end
    res.led_drive = pred_lit ? pred_count : '0;
    res.count_value = pred_count;
    res.press_event = ev;
    return res;
  endfunction

  function automatic void write_pred_reg(input logic [PLCB_ADDR_W-1:0] addr,
                                         input logic [PLCB_TICK_W-1:0] data);
    case (addr)
      REG_LONG_PRESS: pred_cfg.long_press_ticks = data;
      REG_ON_TICKS:   pred_cfg.on_ticks = data;
      REG_OFF_TICKS:  pred_cfg.off_ticks = data;
      default: ;
    endcase
  endfunction

  // mostly short gaps, now and then a long one, none in a calm stretch
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_ticks(input logic level, input int unsigned n);
    script_item_t it;
    it = '{is_cfg: 1'b0, level: level, addr: '0, data: '0};
    repeat (n) button_script.push_back(it);
    script_items += n;
  endtask

  // n pressed ticks then the release tick, the held time comes out as n
  task automatic add_press(input int unsigned n);
    add_ticks(1'b0, n);
    add_ticks(1'b1, 1);
  endtask

  task automatic add_cfg(input logic [PLCB_ADDR_W-1:0] addr,
                         input logic [PLCB_TICK_W-1:0] data);
    script_item_t it;
    it = '{is_cfg: 1'b1, level: 1'b0, addr: addr, data: data};
    button_script.push_back(it);
  endtask

  task automatic add_random_phase(input logic [PLCB_TICK_W-1:0] lp,
                                  input logic [PLCB_TICK_W-1:0] on_t,
                                  input logic [PLCB_TICK_W-1:0] off_t,
                                  input int unsigned n_items);
    int unsigned start;
    int unsigned r;
    int unsigned n;
    int unsigned thr;
    add_cfg(REG_LONG_PRESS, lp);
    add_cfg(REG_ON_TICKS, on_t);
    add_cfg(REG_OFF_TICKS, off_t);
    start = script_items;
    thr = (lp == 0) ? 1 : lp;
    while (script_items - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        // glitches of random level
        add_ticks(1'($urandom_range(0, 1)), $urandom_range(1, 3));
      end else begin
        add_ticks(1'b1, $urandom_range(0, 4));
        if (thr > 64) n = $urandom_range(1, 8);
        else if (thr <= 1 || r < 35) n = thr + $urandom_range(0, 3);
        else n = $urandom_range(1, thr - 1);
        add_press(n);
      end
    end
  endtask

  // stimulus driver: one beat per script entry, writes only when nothing is owed
  int unsigned src_hold;
  bit          src_calm;
  always @(posedge clk_i) begin : drive_proc
    logic tv_n;
    logic cv_n;
    tv_n = s_axis_tvalid;
    cv_n = cfg_valid_i;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_display.push_back(next_tick_display(s_axis_tdata[0]));
        tv_n = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        write_pred_reg(cfg_addr_i, cfg_data_i);
        cv_n = 1'b0;
      end
      if (!tv_n && !cv_n && button_script.size() > 0) begin
        if (src_hold > 0) begin
          src_hold--;
        end else if (button_script[0].is_cfg) begin
          if (expected_display.size() == 0) begin
            cv_n = 1'b1;
            cfg_addr_i <= button_script[0].addr;
            cfg_data_i <= button_script[0].data;
            void'(button_script.pop_front());
            src_hold = pick_gap(src_calm);
          end
        end else begin
          tv_n = 1'b1;
          s_axis_tdata <= {7'd0, button_script[0].level};
          void'(button_script.pop_front());
          if ($urandom_range(0, 49) == 0) src_calm = ~src_calm;
          src_hold = pick_gap(src_calm);
        end
      end
      s_axis_tvalid <= tv_n;
      cfg_valid_i <= cv_n;
    end
  end

  // result monitor with random back pressure
  int unsigned  sink_hold;
  bit           sink_calm;
  always @(posedge clk_i) begin : check_proc
    plcb_result_t got;
    plcb_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = plcb_result_t'(m_axis_tdata[9:0]);
        if (expected_display.size() == 0) begin
          $error("result beat with nothing expected: %h", m_axis_tdata);
          fail_cnt++;
        end else begin
          want = expected_display.pop_front();
          if (got.led_drive !== want.led_drive) begin
            $error("led_drive expected %0d got %0d", want.led_drive, got.led_drive);
            fail_cnt++;
          end
          if (got.count_value !== want.count_value) begin
            $error("count_value expected %0d got %0d", want.count_value, got.count_value);
            fail_cnt++;
          end
          if (got.press_event !== want.press_event) begin
            $error("press_event expected %0d got %0d", want.press_event, got.press_event);
            fail_cnt++;
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 63) == 0) sink_calm = ~sink_calm;
        sink_hold = pick_gap(sink_calm);
      end
    end
  end

  // watchdog on cycles without any beat
  int unsigned idle_cycles;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pred_cfg = '{long_press_ticks: PLCB_LONG_RESET, on_ticks: PLCB_ON_RESET,
                 off_ticks: PLCB_OFF_RESET};
    pred_count = '0;
    pred_held = 1'b0;
    pred_held_ticks = '0;
    pred_blink = 1'b0;
    pred_lit = 1'b1;
    pred_phase_ticks = '0;

    // directed: reset values, release while not held, press while held
    add_ticks(1'b1, 3);
    add_press(1);
    add_press(3);
    add_ticks(1'b1, 2);
    // zero phase lengths behave as one tick each
    add_cfg(REG_ON_TICKS, 16'd0);
    add_cfg(REG_OFF_TICKS, 16'd0);
    add_ticks(1'b1, 4);
    // zero threshold makes every release long
    add_cfg(REG_LONG_PRESS, 16'd0);
    add_press(1);
    add_cfg(REG_UNUSED, 16'hffff);
    add_press(2);
    // hold timing around the threshold: one just short, one just long
    add_cfg(REG_LONG_PRESS, 16'd40);
    add_press(39);
    add_press(40);
    add_ticks(1'b1, 2);

    // random phases, extremes first
    add_random_phase(16'd1, 16'd1, 16'd1, 90);
    add_random_phase(16'hffff, 16'hffff, 16'hffff, 90);
    add_random_phase(16'd3, 16'd1, 16'hffff, 90);
    repeat (5) begin
      add_random_phase(PLCB_TICK_W'($urandom_range(1, 12)),
                       PLCB_TICK_W'($urandom_range(1, 6)),
                       PLCB_TICK_W'($urandom_range(1, 6)), 90);
    end
    add_cfg(REG_UNUSED, PLCB_TICK_W'($urandom_range(0, 16'hffff)));
    add_random_phase(16'd1000, 16'd800, 16'd200, 20);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (button_script.size() != 0 || s_axis_tvalid || cfg_valid_i ||
           expected_display.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/plcb_pkg.sv
src/plcb_core.sv
src/plcb_out_buf.sv
src/press_length_counter_blinker_unit.sv
sim/tb_top.sv
